### sv/ibsc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ibsc_pkg
// Shared types and codes for the IMU, button and supply conditioner.
// ----------------------------------------------------------------------------
package ibsc_pkg;

  // Configuration register indexes
  localparam logic [2:0] CFG_IMU_ALPHA      = 3'd0;
  localparam logic [2:0] CFG_VOLT_ALPHA     = 3'd1;
  localparam logic [2:0] CFG_LONG_PRESS_MS  = 3'd2;
  localparam logic [2:0] CFG_VOLT_STEP      = 3'd3;
  localparam logic [2:0] CFG_REPORT_IVL_MS  = 3'd4;
  localparam logic [2:0] CFG_LOW_VOLT_LEVEL = 3'd5;

  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  // Button event codes
  typedef enum logic [1:0] {
    EV_NONE  = 2'd0,
    EV_SHORT = 2'd1,
    EV_LONG  = 2'd2
  } btn_event_e;

  // Per-button tracking state
  typedef struct packed {
    logic        level;
    logic        long_rep;
    logic [31:0] press_time;
  } btn_state_t;

  // Button update: next state plus the event it raises
  typedef struct packed {
    btn_state_t st;
    btn_event_e ev;
  } btn_step_t;

endpackage

### sv/imu_button_supply_conditioner_unit.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// imu_button_supply_conditioner_unit
// Centres and low-pass filters six IMU axes, turns two buttons into short and
// long press events and tracks a rate-limited supply voltage report.
// ----------------------------------------------------------------------------
//
//  channel | direction | handshake                | payload
//  --------+-----------+--------------------------+--------------------------
//  in      | sink      | in_valid_i / in_stall_o  | raw axes, supply, buttons,
//          |           |                          | now_ms
//  out     | source    | out_valid_o / out_stall_i| filtered axes, events,
//          |           |                          | voltage report
//  cfg     | sink      | cfg_we_i                 | cfg_index_i, cfg_wdata_i
//
//  One item per clock sustained while out_stall_i is low. An item is
//  held in the input register, then the filters, button trackers and
//  supply logic (one 10 x (OUT_W+1) multiplier per axis plus one for the
//  supply) write the result register, which drives out_valid_o.
//  Reset clears all filter, button and supply state and loads the register
//  defaults. A stall on the output only backs up the input when both the
//  input register and the result register are full.
//
module imu_button_supply_conditioner_unit #(
  parameter int unsigned AXIS_BITS = 10,
  parameter int unsigned FRAC_BITS = 8
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,

  // configuration write port
  input  logic                                cfg_we_i,
  input  logic [ibsc_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [ibsc_pkg::CFG_DATA_W-1:0]     cfg_wdata_i,

  // input items
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [AXIS_BITS-1:0]                gyro_raw_x_i,
  input  logic [AXIS_BITS-1:0]                gyro_raw_y_i,
  input  logic [AXIS_BITS-1:0]                gyro_raw_z_i,
  input  logic [AXIS_BITS-1:0]                accel_raw_x_i,
  input  logic [AXIS_BITS-1:0]                accel_raw_y_i,
  input  logic [AXIS_BITS-1:0]                accel_raw_z_i,
  input  logic [7:0]                          supply_raw_i,
  input  logic [7:0]                          button_bits_i,
  input  logic [31:0]                         now_ms_i,

  // result items
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic signed [AXIS_BITS+FRAC_BITS:0] rate_x_o,
  output logic signed [AXIS_BITS+FRAC_BITS:0] rate_y_o,
  output logic signed [AXIS_BITS+FRAC_BITS:0] rate_z_o,
  output logic signed [AXIS_BITS+FRAC_BITS:0] accel_x_o,
  output logic signed [AXIS_BITS+FRAC_BITS:0] accel_y_o,
  output logic signed [AXIS_BITS+FRAC_BITS:0] accel_z_o,
  output ibsc_pkg::btn_event_e                mode_event_o,
  output ibsc_pkg::btn_event_e                start_event_o,
  output logic                                volt_report_o,
  output logic                                volt_low_o,
  output logic [FRAC_BITS+7:0]                volt_level_o
);

  import ibsc_pkg::*;

  // filtered axis width, supply average width, compare width
  localparam int unsigned OUT_W = AXIS_BITS + FRAC_BITS + 1;
  localparam int unsigned VW    = FRAC_BITS + 8;
  localparam int unsigned CW    = (VW > CFG_DATA_W) ? VW : CFG_DATA_W;
  localparam int unsigned PW    = OUT_W + 11;  // axis product
  localparam int unsigned VPW   = VW + 11;     // supply product

  localparam int unsigned ONE_Q   = 1 << FRAC_BITS;
  localparam int unsigned ROUND_Q = 1 << (FRAC_BITS - 1);
  localparam logic [AXIS_BITS-1:0] AXIS_MID = AXIS_BITS'(1) << (AXIS_BITS - 1);

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic logic [8:0] clamp_alpha(logic [8:0] a);
    return (32'(a) > ONE_Q) ? 9'(ONE_Q) : a;
  endfunction

  // raw 0 means no data
  function automatic logic signed [OUT_W-1:0] centre_axis(logic [AXIS_BITS-1:0] r);
    logic signed [AXIS_BITS:0] d;
    d = $signed({1'b0, r}) - $signed({1'b0, AXIS_MID});
    return (r == '0) ? '0 : $signed({d, {FRAC_BITS{1'b0}}});
  endfunction

  // y + floor((a*(x-y) + half) / 2^F), same as the blended form
  function automatic logic signed [OUT_W-1:0] axis_lp(logic [8:0] a,
                                                      logic signed [OUT_W-1:0] x,
                                                      logic signed [OUT_W-1:0] y);
    logic signed [9:0]     as;
    logic signed [OUT_W:0] diff;
    logic signed [PW-1:0]  prod;
    logic signed [PW-1:0]  sh;
    as   = $signed({1'b0, a});
    diff = $signed({x[OUT_W-1], x}) - $signed({y[OUT_W-1], y});
    prod = PW'(as) * PW'(diff);
    sh   = (prod + $signed(PW'(ROUND_Q))) >>> FRAC_BITS;
    return $signed(y + $signed(sh[OUT_W-1:0]));
  endfunction

  function automatic logic [VW-1:0] volt_lp(logic [8:0] a, logic [VW-1:0] x,
                                            logic [VW-1:0] y);
    logic signed [9:0]     as;
    logic signed [VW:0]    diff;
    logic signed [VPW-1:0] prod;
    logic signed [VPW-1:0] sh;
    as   = $signed({1'b0, a});
    diff = $signed({1'b0, x}) - $signed({1'b0, y});
    prod = VPW'(as) * VPW'(diff);
    sh   = (prod + $signed(VPW'(ROUND_Q))) >>> FRAC_BITS;
    return y + sh[VW-1:0];
  endfunction

  function automatic btn_step_t btn_update(btn_state_t s, logic pushed,
                                           logic [31:0] now, logic [15:0] long_ms);
    btn_step_t   r;
    logic [31:0] held;
    held = now - s.press_time;
    r.st = s;
    r.ev = EV_NONE;
    if (s.level == pushed) begin
      if (pushed && !s.long_rep && (held > {16'b0, long_ms})) begin
        r.ev         = EV_LONG;
        r.st.long_rep = 1'b1;
      end
    end else begin
      r.st.level = pushed;
      if (pushed) begin
        r.st.press_time = now;
        r.st.long_rep   = 1'b0;
      end else if (held < {16'b0, long_ms}) begin
        r.ev = EV_SHORT;
      end
    end
    return r;
  endfunction

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [8:0]  imu_alpha_q, volt_alpha_q;
  logic [15:0] long_press_q, volt_step_q, report_ivl_q;
  logic [7:0]  low_volt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imu_alpha_q  <= 9'd102;
      volt_alpha_q <= 9'd102;
      long_press_q <= 16'd2000;
      volt_step_q  <= 16'd256;
      report_ivl_q <= 16'd1000;
      low_volt_q   <= 8'd110;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CFG_IMU_ALPHA:      imu_alpha_q  <= cfg_wdata_i[8:0];
        CFG_VOLT_ALPHA:     volt_alpha_q <= cfg_wdata_i[8:0];
        CFG_LONG_PRESS_MS:  long_press_q <= cfg_wdata_i;
        CFG_VOLT_STEP:      volt_step_q  <= cfg_wdata_i;
        CFG_REPORT_IVL_MS:  report_ivl_q <= cfg_wdata_i;
        CFG_LOW_VOLT_LEVEL: low_volt_q   <= cfg_wdata_i[7:0];
        default: ;  // unused index, write dropped
      endcase
    end
  end

  // --------------------------------------------------------------------------
  // Handshake: input register -> result register
  // --------------------------------------------------------------------------
  logic s1_valid_q, out_valid_q;
  logic out_ready, adv, in_accept;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign adv        = s1_valid_q && out_ready;
  assign in_stall_o = s1_valid_q && !out_ready;
  assign in_accept  = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_accept) begin
        s1_valid_q <= 1'b1;
      end else if (adv) begin
        s1_valid_q <= 1'b0;
      end
      if (adv) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // input register payload; only the mode and start bits are kept
  logic [AXIS_BITS-1:0] gyro_q [3];
  logic [AXIS_BITS-1:0] accr_q [3];
  logic [7:0]           supply_q;
  logic [1:0]           buttons_q;
  logic [31:0]          now_q;

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      gyro_q[0] <= gyro_raw_x_i;
      gyro_q[1] <= gyro_raw_y_i;
      gyro_q[2] <= gyro_raw_z_i;
      accr_q[0] <= accel_raw_x_i;
      accr_q[1] <= accel_raw_y_i;
      accr_q[2] <= accel_raw_z_i;
      supply_q  <= supply_raw_i;
      buttons_q <= button_bits_i[1:0];
      now_q     <= now_ms_i;
    end
  end

  // --------------------------------------------------------------------------
  // Processing state and next-state logic
  // --------------------------------------------------------------------------
  logic signed [OUT_W-1:0] rate_q [3], rate_d [3];
  logic signed [OUT_W-1:0] acc_q  [3], acc_d  [3];
  logic signed [OUT_W-1:0] acc_in [3];
  btn_state_t              btn_q  [2];
  btn_step_t               btn_s  [2];
  logic [VW-1:0]           avg_q, avg_d, vrep_q, vrep_d, sample, vdiff;
  logic [31:0]             last_rep_q, last_rep_d;
  logic [8:0]              a_imu;
  logic                    report_d;

  assign a_imu = clamp_alpha(imu_alpha_q);

  // robot frame: x = -raw y, y = raw x, z = -raw z
  assign acc_in[0] = -centre_axis(accr_q[1]);
  assign acc_in[1] =  centre_axis(accr_q[0]);
  assign acc_in[2] = -centre_axis(accr_q[2]);

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rate_d[i] = axis_lp(a_imu, centre_axis(gyro_q[i]), rate_q[i]);
      acc_d[i]  = axis_lp(a_imu, acc_in[i], acc_q[i]);
    end
  end

  assign btn_s[0] = btn_update(btn_q[0], buttons_q[0], now_q, long_press_q);
  assign btn_s[1] = btn_update(btn_q[1], buttons_q[1], now_q, long_press_q);

  // supply: first sample loads the average directly
  assign sample = {supply_q, {FRAC_BITS{1'b0}}};
  assign avg_d  = (avg_q == '0) ? sample
                                : volt_lp(clamp_alpha(volt_alpha_q), sample, avg_q);
  assign vdiff  = (vrep_q > avg_d) ? (vrep_q - avg_d) : (avg_d - vrep_q);

  always_comb begin
    report_d   = (CW'(vdiff) >= CW'(volt_step_q)) &&
                 ((now_q - last_rep_q) >= {16'b0, report_ivl_q});
    vrep_d     = report_d ? avg_d : vrep_q;
    last_rep_d = report_d ? now_q : last_rep_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < 3; i++) begin
        rate_q[i] <= '0;
        acc_q[i]  <= '0;
      end
      btn_q[0]   <= '0;
      btn_q[1]   <= '0;
      avg_q      <= '0;
      vrep_q     <= '0;
      last_rep_q <= '0;
    end else if (adv) begin
      for (int i = 0; i < 3; i++) begin
        rate_q[i] <= rate_d[i];
        acc_q[i]  <= acc_d[i];
      end
      btn_q[0]   <= btn_s[0].st;
      btn_q[1]   <= btn_s[1].st;
      avg_q      <= avg_d;
      vrep_q     <= vrep_d;
      last_rep_q <= last_rep_d;
    end
  end

  // --------------------------------------------------------------------------
  // Result register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (adv) begin
      rate_x_o      <= rate_d[0];
      rate_y_o      <= rate_d[1];
      rate_z_o      <= rate_d[2];
      accel_x_o     <= acc_d[0];
      accel_y_o     <= acc_d[1];
      accel_z_o     <= acc_d[2];
      mode_event_o  <= btn_s[0].ev;
      start_event_o <= btn_s[1].ev;
      volt_report_o <= report_d;
      volt_low_o    <= (vrep_d < {low_volt_q, {FRAC_BITS{1'b0}}});
      volt_level_o  <= vrep_d;
    end
  end

  assign out_valid_o = out_valid_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (out_valid_o && out_stall_i && s1_valid_q))
    else $error("input stalled while result register can take an item");

  a_adv_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    adv |=> out_valid_o)
    else $error("advanced item did not reach the result register");

  a_long_marks_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && btn_s[0].ev == EV_LONG) |=> (btn_q[0].level && btn_q[0].long_rep))
    else $error("long press raised without held, marked button");

  a_short_on_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && btn_s[1].ev == EV_SHORT) |=> !btn_q[1].level)
    else $error("short press raised while button still held");

  a_report_tracks_avg: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && report_d) |=> (vrep_q == avg_q && volt_level_o == avg_q))
    else $error("reported level does not follow the average");

endmodule
